// ===== hw/rtl/ebj_pkg.sv =====
`default_nettype none

package ebj_pkg;

  // Field widths of the transaction payloads and the configuration port.
  localparam int unsigned OP_W       = 2;
  localparam int unsigned TIME_W     = 48;
  localparam int unsigned TIMEOUT_W  = 32;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned SEED_W     = 31;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned MUL_W      = 32;

  // Linear congruential generator constants.
  localparam logic [MUL_W-1:0]  LCG_MUL = 32'd1103515245;
  localparam logic [SEED_W-1:0] LCG_ADD = 31'd12345;

  // Register values after reset.
  localparam logic [FRAC_W-1:0]    MULT_RESET   = 16'd410;
  localparam logic [FRAC_W-1:0]    JITTER_RESET = 16'd13107;
  localparam logic [TIMEOUT_W-1:0] MIN_RESET    = 32'd1000;
  localparam logic [TIMEOUT_W-1:0] MAX_RESET    = 32'd120000;
  localparam logic [SEED_W-1:0]    SEED_RESET   = 31'd1;

  // Operation codes of an input transaction; code 3 has no meaning.
  typedef enum logic [OP_W-1:0] {
    OP_BEGIN = 2'd0,
    OP_STEP  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MULT   = 3'd0,
    REG_JITTER = 3'd1,
    REG_MIN    = 3'd2,
    REG_MAX    = 3'd3,
    REG_SEED   = 3'd4
  } reg_idx_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LCG,
    ST_GROW,
    ST_JIT,
    ST_FACT,
    ST_P0,
    ST_P1,
    ST_P2,
    ST_P3,
    ST_P4,
    ST_CLAMP,
    ST_DONE
  } state_t;

  // Configuration handed from the register bank to the sequencer.
  typedef struct packed {
    logic [FRAC_W-1:0]    mult;
    logic [FRAC_W-1:0]    jitter;
    logic [TIMEOUT_W-1:0] min_timeout;
    logic [TIMEOUT_W-1:0] max_timeout;
    logic                 seed_load;
    logic [SEED_W-1:0]    seed;
  } cfg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ebj_if.sv =====
`default_nettype none

// Input channel: operation and current time.
interface ebj_in_if import ebj_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [OP_W-1:0]       operation;
  logic [TIME_W-1:0]     now_ms;

  modport source (output valid, output operation, output now_ms, input ready);
  modport sink (input valid, input operation, input now_ms, output ready);
endinterface

// Output channel: new timeout and deadline.
interface ebj_out_if import ebj_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [TIMEOUT_W-1:0]  timeout_ms;
  logic [TIME_W-1:0]     deadline_ms;

  modport source (output valid, output timeout_ms, output deadline_ms, input ready);
  modport sink (input valid, input timeout_ms, input deadline_ms, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ebj_cfg_regs.sv =====
`default_nettype none

module ebj_cfg_regs import ebj_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                       cfg
);

  logic [FRAC_W-1:0]    mult;
  logic [FRAC_W-1:0]    jitter;
  logic [TIMEOUT_W-1:0] min_timeout;
  logic [TIMEOUT_W-1:0] max_timeout;

  // Register writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      mult        <= MULT_RESET;
      jitter      <= JITTER_RESET;
      min_timeout <= MIN_RESET;
      max_timeout <= MAX_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MULT:   mult        <= cfg_data[FRAC_W-1:0];
        REG_JITTER: jitter      <= cfg_data[FRAC_W-1:0];
        REG_MIN:    min_timeout <= cfg_data[TIMEOUT_W-1:0];
        REG_MAX:    max_timeout <= cfg_data[TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  // A seed write loads the generator state directly, so it travels as a pulse.
  always_comb begin
    cfg.mult        = mult;
    cfg.jitter      = jitter;
    cfg.min_timeout = min_timeout;
    cfg.max_timeout = max_timeout;
    cfg.seed_load   = cfg_write && (cfg_index == REG_SEED);
    cfg.seed        = cfg_data[SEED_W-1:0];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ebj_mul.sv =====
`default_nettype none

module ebj_mul import ebj_pkg::*; (
  input  wire logic               clk,
  input  wire logic [MUL_W-1:0]   a,
  input  wire logic [MUL_W-1:0]   b,
  output logic      [2*MUL_W-1:0] prod
);

  // Shared unsigned multiplier with a registered product.
  always_ff @(posedge clk) begin
    prod <= {{MUL_W{1'b0}}, a} * {{MUL_W{1'b0}}, b};
  end

endmodule

`default_nettype wire

// ===== hw/rtl/exponential_backoff_jitter_core.sv =====
`default_nettype none

// Retry backoff timer. A begin transaction loads the timeout with the minimum,
// a step transaction grows it by the Q8.8 multiplier, adds a random jitter of
// up to plus or minus the Q0.16 jitter fraction of the grown value and clamps
// it to the range from minimum to maximum (minimum tested first); both report
// the timeout and the deadline now plus timeout, modulo 2^48. A clear
// transaction zeroes the timeout and reports nothing. One input transaction
// is taken at a time. A begin result passes from the final state into the
// output register; a step first makes seven passes through one shared 32 by
// 32 multiplier (generator update, growth, jitter scaling and four partial
// products of the 48 by 48 bit jitter product) and then the clamp. With the
// output free, the sequencer goes from its final state back to idle for the
// next transaction, and a clear leaves it idle. A result that is not taken
// holds the sequencer in its final state. Configuration may be written only
// while the block is idle.
module exponential_backoff_jitter_core import ebj_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  ebj_in_if.sink                     in_item,
  ebj_out_if.source                  out_item
);

  localparam int unsigned ACC_W = 4 * MUL_W - 2 * FRAC_W;
  localparam int unsigned V_LSB = 55;
  localparam int unsigned V_W   = ACC_W - V_LSB;
  localparam logic [TIME_W-1:0] F_BASE = {1'b1, {(TIME_W-1){1'b0}}};

  cfg_t   cfg;
  state_t state;
  state_t state_next;

  logic [MUL_W-1:0]     mul_a;
  logic [MUL_W-1:0]     mul_b;
  logic [2*MUL_W-1:0]   prod;

  logic [TIME_W-1:0]    now_reg;
  logic [TIMEOUT_W-1:0] cur;
  logic [SEED_W-1:0]    lcg;
  logic [TIME_W-1:0]    n_reg;
  logic [TIME_W-1:0]    f_reg;
  logic [ACC_W-1:0]     acc;
  logic [V_W-1:0]       v;
  logic                 out_free;
  logic                 in_accept;

  ebj_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ebj_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  assign in_accept = in_item.valid && in_item.ready;
  assign out_free  = !out_item.valid || out_item.ready;
  assign v         = acc[ACC_W-1:V_LSB];

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, input ready and multiplier operands.
  always_comb begin
    state_next    = state;
    in_item.ready = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    case (state)
      ST_IDLE: begin
        in_item.ready = 1'b1;
        if (in_item.valid) begin
          case (in_item.operation)
            OP_BEGIN: state_next = ST_DONE;
            OP_STEP:  state_next = ST_LCG;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_LCG: begin
        mul_a      = LCG_MUL;
        mul_b      = {1'b0, lcg};
        state_next = ST_GROW;
      end
      ST_GROW: begin
        mul_a      = {{(MUL_W-FRAC_W){1'b0}}, cfg.mult};
        mul_b      = cur;
        state_next = ST_JIT;
      end
      ST_JIT: begin
        mul_a      = {{(MUL_W-FRAC_W){1'b0}}, cfg.jitter};
        mul_b      = {1'b0, lcg};
        state_next = ST_FACT;
      end
      ST_FACT: begin
        state_next = ST_P0;
      end
      ST_P0: begin
        mul_a      = n_reg[MUL_W-1:0];
        mul_b      = f_reg[MUL_W-1:0];
        state_next = ST_P1;
      end
      ST_P1: begin
        mul_a      = n_reg[MUL_W-1:0];
        mul_b      = {{(2*MUL_W-TIME_W){1'b0}}, f_reg[TIME_W-1:MUL_W]};
        state_next = ST_P2;
      end
      ST_P2: begin
        mul_a      = {{(2*MUL_W-TIME_W){1'b0}}, n_reg[TIME_W-1:MUL_W]};
        mul_b      = f_reg[MUL_W-1:0];
        state_next = ST_P3;
      end
      ST_P3: begin
        mul_a      = {{(2*MUL_W-TIME_W){1'b0}}, n_reg[TIME_W-1:MUL_W]};
        mul_b      = {{(2*MUL_W-TIME_W){1'b0}}, f_reg[TIME_W-1:MUL_W]};
        state_next = ST_P4;
      end
      ST_P4: begin
        state_next = ST_CLAMP;
      end
      ST_CLAMP: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Timeout and generator state.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= '0;
      lcg <= SEED_RESET;
    end else begin
      if (cfg.seed_load) begin
        lcg <= cfg.seed;
      end else if (state == ST_GROW) begin
        lcg <= prod[SEED_W-1:0] + LCG_ADD;
      end
      if (in_accept && in_item.operation == OP_BEGIN) begin
        cur <= cfg.min_timeout;
      end else if (in_accept && in_item.operation == OP_CLEAR) begin
        cur <= '0;
      end else if (state == ST_CLAMP) begin
        if (v < {{(V_W-TIMEOUT_W){1'b0}}, cfg.min_timeout}) begin
          cur <= cfg.min_timeout;
        end else if (v > {{(V_W-TIMEOUT_W){1'b0}}, cfg.max_timeout}) begin
          cur <= cfg.max_timeout;
        end else begin
          cur <= v[TIMEOUT_W-1:0];
        end
      end
    end
  end

  // Datapath registers: input time, grown timeout, jitter factor, product accumulator.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      now_reg <= in_item.now_ms;
    end
    case (state)
      ST_JIT:  n_reg <= prod[TIME_W-1:0];
      ST_FACT: f_reg <= F_BASE - {1'b0, cfg.jitter, {SEED_W{1'b0}}}
                        + {prod[TIME_W-2:0], 1'b0};
      ST_P1:   acc <= {{(ACC_W-2*MUL_W){1'b0}}, prod};
      ST_P2:   acc <= acc + {prod, {MUL_W{1'b0}}};
      ST_P3:   acc <= acc + {prod, {MUL_W{1'b0}}};
      ST_P4:   acc <= acc + {prod[MUL_W-1:0], {(2*MUL_W){1'b0}}};
      default: ;
    endcase
  end

  // Output register: loaded from the final state once the channel is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_item.valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_item.valid <= 1'b1;
    end else if (out_item.ready) begin
      out_item.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      out_item.timeout_ms  <= cur;
      out_item.deadline_ms <= now_reg + {{(TIME_W-TIMEOUT_W){1'b0}}, cur};
    end
  end

  // A clamped timeout is the minimum, the maximum or lies strictly between.
  a_clamp_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLAMP |=> cur == $past(cfg.min_timeout) || cur == $past(cfg.max_timeout)
      || (cur > $past(cfg.min_timeout) && cur < $past(cfg.max_timeout)))
    else $error("clamped timeout outside the configured range");

  // A begin transaction loads the minimum and heads for the result.
  a_begin_load: assert property (@(posedge clk) disable iff (rst)
    in_accept && in_item.operation == OP_BEGIN
      |=> cur == $past(cfg.min_timeout) && state == ST_DONE)
    else $error("begin did not load the minimum timeout");

  // A clear transaction zeroes the timeout and produces no result.
  a_clear: assert property (@(posedge clk) disable iff (rst)
    in_accept && in_item.operation == OP_CLEAR |=> cur == '0 && state == ST_IDLE)
    else $error("clear did not zero the timeout");

  // A result appears only out of the final state.
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_item.valid) |-> $past(state == ST_DONE))
    else $error("result presented outside the final state");

endmodule

`default_nettype wire

// ===== tb/sv/exponential_backoff_jitter_core_tb.sv =====
module exponential_backoff_jitter_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ebj_pkg::*;

  localparam int unsigned IDLE_PCT      = 23;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned DRAIN_LIMIT   = 4000;
  localparam int unsigned CYCLE_LIMIT   = 500000;
  localparam int unsigned REPORT_LIMIT  = 10;
  localparam int unsigned N_DIRECTED    = 22;
  localparam int unsigned N_PHASES      = 8;
  localparam int unsigned PHASE_ITEMS   = 128;

  localparam logic [OP_W-1:0]   OP_UNUSED = 2'd3;
  localparam logic [TIME_W-1:0] TIME_MAX  = '1;

  // One expected result: the timeout and its deadline.
  typedef struct packed {
    logic [TIMEOUT_W-1:0] timeout;
    logic [TIME_W-1:0]    deadline;
  } backoff_result_t;

  // One row of the directed table; typed rows carry a hand-written result.
  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [TIME_W-1:0]    now;
    logic                 typed;
    logic [TIMEOUT_W-1:0] timeout;
    logic [TIME_W-1:0]    deadline;
  } directed_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ebj_in_if  in_ch ();
  ebj_out_if out_ch ();

  exponential_backoff_jitter_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_ch),
    .out_item  (out_ch)
  );

  // Mirror of the block's registers and state.
  logic [FRAC_W-1:0]    mult_mirror;
  logic [FRAC_W-1:0]    jitter_mirror;
  logic [TIMEOUT_W-1:0] min_mirror;
  logic [TIMEOUT_W-1:0] max_mirror;
  logic [SEED_W-1:0]    lcg_mirror;
  logic [TIMEOUT_W-1:0] timeout_mirror;

  backoff_result_t due_results[$];
  directed_row_t   directed_rows [N_DIRECTED];
  int unsigned     mismatch_count = 0;
  int unsigned     cycle_count = 0;
  bit              calm = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("[%0t] %s", $realtime, msg);
    end
  endfunction

  // Advance the generator, grow the timeout, apply the jitter and clamp.
  function automatic logic [TIMEOUT_W-1:0] grow_timeout();
    logic [63:0]  lcg_next;
    logic [47:0]  grown;
    logic [63:0]  factor;
    logic [127:0] product;
    logic [63:0]  scaled;
    lcg_next = 64'(LCG_MUL) * 64'(lcg_mirror) + 64'(LCG_ADD);
    lcg_mirror = lcg_next[SEED_W-1:0];
    grown = 48'(mult_mirror) * 48'(timeout_mirror);
    // The factor 2^47 + J * (2 * lcg - 2^31) never drops below zero.
    factor = (64'd1 << 47) - (64'(jitter_mirror) << 31)
             + ((64'(jitter_mirror) * 64'(lcg_mirror)) << 1);
    product = 128'(grown) * 128'(factor);
    scaled = 64'(product >> 55);
    if (scaled < 64'(min_mirror)) begin
      return min_mirror;
    end
    if (scaled > 64'(max_mirror)) begin
      return max_mirror;
    end
    return scaled[TIMEOUT_W-1:0];
  endfunction

  // Apply one input transaction to the mirror; returns whether a result follows.
  function automatic bit predict_backoff(input logic [OP_W-1:0] op,
                                         input logic [TIME_W-1:0] now,
                                         output backoff_result_t res);
    res = '0;
    case (op)
      OP_BEGIN: begin
        timeout_mirror = min_mirror;
      end
      OP_STEP: begin
        timeout_mirror = grow_timeout();
      end
      OP_CLEAR: begin
        timeout_mirror = '0;
        return 1'b0;
      end
      default: begin
        return 1'b0;
      end
    endcase
    res.timeout = timeout_mirror;
    res.deadline = now + TIME_W'(timeout_mirror);
    return 1'b1;
  endfunction

  function automatic logic [TIME_W-1:0] rand_now();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    case ($urandom_range(9))
      0: return TIME_MAX - TIME_W'($urandom_range(0, 200000));
      1: return TIME_W'($urandom_range(0, 1000));
      default: return raw[TIME_W-1:0];
    endcase
  endfunction

  // Offer one input transaction and wait until it is taken.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [TIME_W-1:0] now);
    @(negedge clk);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.now_ms <= now;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_predicted(input logic [OP_W-1:0] op, input logic [TIME_W-1:0] now);
    backoff_result_t res;
    send_item(op, now);
    if (predict_backoff(op, now, res)) begin
      due_results.push_back(res);
    end
  endtask

  // Stop sending and let every outstanding transaction complete.
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_MULT:   mult_mirror = data[FRAC_W-1:0];
      REG_JITTER: jitter_mirror = data[FRAC_W-1:0];
      REG_MIN:    min_mirror = data[TIMEOUT_W-1:0];
      REG_MAX:    max_mirror = data[TIMEOUT_W-1:0];
      REG_SEED:   lcg_mirror = data[SEED_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic program_regs(input logic [CFG_DATA_W-1:0] mult, input logic [CFG_DATA_W-1:0] jit,
                              input logic [CFG_DATA_W-1:0] lo, input logic [CFG_DATA_W-1:0] hi,
                              input logic [CFG_DATA_W-1:0] seed);
    write_reg(REG_MULT, mult);
    write_reg(REG_JITTER, jit);
    write_reg(REG_MIN, lo);
    write_reg(REG_MAX, hi);
    write_reg(REG_SEED, seed);
  endtask

  // Retry sequences: mostly a begin followed by a run of steps, with some noise.
  task automatic run_phase(input int unsigned target);
    int unsigned sent;
    int unsigned burst;
    sent = 0;
    while (sent < target) begin
      if ($urandom_range(9) != 0) begin
        send_predicted(OP_BEGIN, rand_now());
        sent++;
      end
      burst = $urandom_range(1, 14);
      for (int unsigned k = 0; k < burst && sent < target; k++) begin
        case ($urandom_range(19))
          0: begin
            send_predicted(OP_CLEAR, rand_now());
            sent++;
          end
          1: send_predicted(OP_UNUSED, rand_now());
          default: begin
            send_predicted(OP_STEP, rand_now());
            sent++;
          end
        endcase
      end
    end
  endtask

  // Receiver back-pressure.
  always @(negedge clk) begin
    out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // Compare each result transaction with the oldest expectation.
  always @(posedge clk) begin
    backoff_result_t exp_res;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (due_results.size() == 0) begin
        note_mismatch($sformatf("unexpected result timeout %0d deadline %0d",
                                out_ch.timeout_ms, out_ch.deadline_ms));
      end else begin
        exp_res = due_results.pop_front();
        if (out_ch.timeout_ms !== exp_res.timeout) begin
          note_mismatch($sformatf("timeout_ms expected %0d got %0d",
                                  exp_res.timeout, out_ch.timeout_ms));
        end
        if (out_ch.deadline_ms !== exp_res.deadline) begin
          note_mismatch($sformatf("deadline_ms expected %0d got %0d",
                                  exp_res.deadline, out_ch.deadline_ms));
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    backoff_result_t res;
    in_ch.valid = 1'b0;
    in_ch.operation = '0;
    in_ch.now_ms = '0;
    out_ch.ready = 1'b0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mult_mirror = MULT_RESET;
    jitter_mirror = JITTER_RESET;
    min_mirror = MIN_RESET;
    max_mirror = MAX_RESET;
    lcg_mirror = SEED_RESET;
    timeout_mirror = '0;

    // Directed rows at the reset configuration.
    directed_rows = '{
      '{OP_STEP,   48'd0,               1'b1, 32'd1000, 48'd1000},
      '{OP_BEGIN,  48'd5,               1'b1, 32'd1000, 48'd1005},
      '{OP_BEGIN,  TIME_MAX,            1'b1, 32'd1000, 48'd999},
      '{OP_STEP,   48'h0000_0000_0001,  1'b0, 32'd0,    48'd0},
      '{OP_STEP,   48'h5555_5555_5555,  1'b0, 32'd0,    48'd0},
      '{OP_STEP,   48'hAAAA_AAAA_AAAA,  1'b0, 32'd0,    48'd0},
      '{OP_STEP,   48'h8000_0000_0000,  1'b0, 32'd0,    48'd0},
      '{OP_STEP,   TIME_MAX,            1'b0, 32'd0,    48'd0},
      '{OP_UNUSED, 48'h0000_1234_5678,  1'b0, 32'd0,    48'd0},
      '{OP_STEP,   48'h0123_4567_89AB,  1'b0, 32'd0,    48'd0},
      '{OP_STEP,   48'hFEDC_BA98_7654,  1'b0, 32'd0,    48'd0},
      '{OP_STEP,   48'd100,             1'b0, 32'd0,    48'd0},
      '{OP_STEP,   48'd200,             1'b0, 32'd0,    48'd0},
      '{OP_STEP,   48'd300,             1'b0, 32'd0,    48'd0},
      '{OP_STEP,   48'd400,             1'b0, 32'd0,    48'd0},
      '{OP_STEP,   48'd500,             1'b0, 32'd0,    48'd0},
      '{OP_STEP,   TIME_MAX,            1'b0, 32'd0,    48'd0},
      '{OP_CLEAR,  TIME_MAX,            1'b0, 32'd0,    48'd0},
      '{OP_UNUSED, 48'd0,               1'b0, 32'd0,    48'd0},
      '{OP_STEP,   48'd7,               1'b1, 32'd1000, 48'd1007},
      '{OP_BEGIN,  48'hFFFF_FFFF_FC18,  1'b1, 32'd1000, 48'd0},
      '{OP_STEP,   48'hFFFF_FFFF_0000,  1'b0, 32'd0,    48'd0}
    };

    repeat (10) @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].op, directed_rows[i].now);
      if (predict_backoff(directed_rows[i].op, directed_rows[i].now, res)) begin
        if (directed_rows[i].typed) begin
          res.timeout = directed_rows[i].timeout;
          res.deadline = directed_rows[i].deadline;
        end
        due_results.push_back(res);
      end
    end
    settle();

    // Random phases, each under its own register setting.
    for (int unsigned p = 0; p < N_PHASES; p++) begin
      case (p)
        0: program_regs($urandom_range(256, 600), $urandom_range(0, 65535),
                        32'd1000, 32'd120000, $urandom);
        1: program_regs(32'd256, 32'd0, $urandom_range(0, 5000),
                        $urandom_range(5000, 1000000), $urandom);
        2: program_regs(32'd65535, 32'd65535, 32'd0, 32'hFFFF_FFFF, 32'd0);
        3: begin
          // Minimum above maximum, then writes to indexes with no register.
          program_regs($urandom_range(256, 65535), $urandom_range(0, 65535),
                       32'd5000, 32'd100, 32'hFFFF_FFFF);
          for (int i = int'(REG_SEED) + 1; i < (1 << CFG_IDX_W); i++) begin
            write_reg(CFG_IDX_W'(i), $urandom);
          end
        end
        4: program_regs(32'd257, 32'd65535, 32'd1, 32'd3, 32'h7FFF_FFFF);
        5: program_regs($urandom_range(256, 65535), $urandom_range(0, 65535),
                        32'hFFFF_FFFF, 32'hFFFF_FFFF, $urandom);
        6: program_regs($urandom_range(256, 65535), $urandom, $urandom, $urandom, $urandom);
        default: program_regs($urandom_range(256, 1024), $urandom_range(0, 65535),
                              32'd0, $urandom, $urandom);
      endcase
      calm = (p == 4);
      if (p == 6) begin
        // Hold the sender off halfway until every result is back.
        run_phase(PHASE_ITEMS / 2);
        settle();
        run_phase(PHASE_ITEMS / 2);
      end else begin
        run_phase(PHASE_ITEMS);
      end
      settle();
    end
    calm = 1'b0;

    // Final drain with a bound; anything still outstanding is a failure.
    for (int unsigned w = 0; w < DRAIN_LIMIT && due_results.size() != 0; w++) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (due_results.size() != 0) begin
      res = due_results.pop_front();
      note_mismatch($sformatf("missing result timeout %0d deadline %0d",
                              res.timeout, res.deadline));
    end

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
